[hw/rtl/hierarchical_bitmap_successor_unit_assert.svh]
// assertion macros for the successor unit
`ifndef HIERARCHICAL_BITMAP_SUCCESSOR_UNIT_ASSERT_SVH
`define HIERARCHICAL_BITMAP_SUCCESSOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define HBSU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define HBSU_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HBSU_ASSERT(label, prop, msg)
`define HBSU_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[hw/rtl/hbsu_pkg.sv]
package hbsu_pkg;

	localparam int WORD_BITS = 64;
	localparam int WORD_LOG = 6;
	localparam int KEY_BITS = 18;
	localparam int MID_ADDR_BITS = KEY_BITS - 2 * WORD_LOG;
	localparam int LEAF_ADDR_BITS = KEY_BITS - WORD_LOG;
	localparam int MID_DEPTH = 1 << MID_ADDR_BITS;
	localparam int LEAF_DEPTH = 1 << LEAF_ADDR_BITS;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [WORD_LOG-1:0] digit_t;
	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [LEAF_ADDR_BITS-1:0] leaf_addr_t;
	typedef logic [MID_ADDR_BITS-1:0] mid_addr_t;

	localparam logic [1:0] REQ_TOGGLE = 2'd0;
	localparam logic [1:0] REQ_NEXT = 2'd1;
	localparam logic [1:0] REQ_PREV = 2'd2;
	localparam logic [1:0] REQ_NONE = 2'd3;

	// index of the lowest set bit, zero for an empty word
	function automatic digit_t lsb_index(input word_t w);
		word_t iso;
		digit_t idx;
		iso = w & (~w + word_t'(1));
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (iso[i]) begin
				idx = idx | digit_t'(i);
			end
		end
		return idx;
	endfunction

	// index of the highest set bit, zero for an empty word
	function automatic digit_t msb_index(input word_t w);
		word_t rev;
		for (int i = 0; i < WORD_BITS; i++) begin
			rev[i] = w[WORD_BITS-1-i];
		end
		if (w == '0) begin
			return '0;
		end
		return digit_t'(WORD_BITS - 1) - lsb_index(rev);
	endfunction

	function automatic digit_t pick_index(input logic upward, input word_t w);
		return upward ? lsb_index(w) : msb_index(w);
	endfunction

	// bits at or above a digit (inclusive) or strictly above it, or strictly below it
	function automatic word_t search_mask(input logic upward, input logic inclusive,
			input digit_t d);
		word_t up_mask;
		up_mask = {WORD_BITS{1'b1}} << d;
		if (!upward) begin
			return ~up_mask;
		end
		return inclusive ? up_mask : (up_mask << 1);
	endfunction

endpackage

[hw/rtl/hierarchical_bitmap_successor_unit.sv]
// channel  | handshake            | payload
// ---------+----------------------+-------------------
// request  | req_valid, req_stall | req_type, key
// result   | res_valid, res_stall | found, position
//
// a toggle returns to idle after S_LOOK; a search makes one synchronous read per tree level
// visited on the way down (leaf and middle words are read together on the way up)
// after reset the leaf and middle memories are cleared one word a cycle with req_stall high
// the result sits in an output register, so the next request is taken while it waits;
// a stalled result holds the following search in its last cycle until the register frees up
`include "hierarchical_bitmap_successor_unit_assert.svh"

module hierarchical_bitmap_successor_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [1:0]                   req_type,
	input  logic [hbsu_pkg::KEY_BITS-1:0] key,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic                         found,
	output logic [hbsu_pkg::KEY_BITS-1:0] position
);

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_LOOK   = 7'b0000100,
		S_DECIDE = 7'b0001000,
		S_MID    = 7'b0010000,
		S_LEAF   = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	localparam int LO = hbsu_pkg::WORD_LOG;

	state_t state_q, state_d;

	hbsu_pkg::word_t leaf_mem [hbsu_pkg::LEAF_DEPTH];
	hbsu_pkg::word_t mid_mem [hbsu_pkg::MID_DEPTH];
	hbsu_pkg::word_t top_q;
	hbsu_pkg::word_t leaf_rd_q, mid_rd_q;

	hbsu_pkg::leaf_addr_t clr_q;
	logic [1:0]           op_q;
	hbsu_pkg::key_t       key_q;

	logic             hit0_q, hit1_q, hit2_q;
	hbsu_pkg::digit_t r0_q, r1_q, r2_q;
	hbsu_pkg::mid_addr_t  top_idx_q;
	hbsu_pkg::leaf_addr_t leaf_idx_q;

	logic           fnd_q;
	hbsu_pkg::key_t pos_q;
	logic           res_valid_q, res_found_q;
	hbsu_pkg::key_t res_pos_q;

	logic                 accept, upward, load_out;
	logic                 leaf_re, mid_re, leaf_we, mid_we;
	hbsu_pkg::leaf_addr_t leaf_ra, leaf_wa;
	hbsu_pkg::mid_addr_t  mid_ra, mid_wa;
	hbsu_pkg::word_t      leaf_wd, mid_wd, leaf_new, mid_new;
	hbsu_pkg::word_t      lw, mw, tw;
	hbsu_pkg::digit_t     d_hi, d_md, d_lo, mid_pick, leaf_pick;

	assign req_stall = (state_q != S_IDLE);
	assign accept = req_valid && !req_stall;
	assign upward = (op_q == hbsu_pkg::REQ_NEXT);

	assign d_hi = key_q[hbsu_pkg::KEY_BITS-1 -: LO];
	assign d_md = key_q[2*LO-1 -: LO];
	assign d_lo = key_q[LO-1:0];

	// words masked to the search range at each level
	assign lw = leaf_rd_q & hbsu_pkg::search_mask(upward, 1'b1, d_lo);
	assign mw = mid_rd_q & hbsu_pkg::search_mask(upward, 1'b0, d_md);
	assign tw = top_q & hbsu_pkg::search_mask(upward, 1'b0, d_hi);

	assign mid_pick = hbsu_pkg::pick_index(upward, mid_rd_q);
	assign leaf_pick = hbsu_pkg::pick_index(upward, leaf_rd_q);

	// toggle read-modify-write
	always_comb begin
		leaf_new = leaf_rd_q ^ (hbsu_pkg::word_t'(1) << d_lo);
		mid_new = mid_rd_q;
		mid_new[d_md] = (leaf_new != '0);
	end

	always_comb begin
		leaf_re = 1'b0;
		leaf_ra = key[hbsu_pkg::KEY_BITS-1:LO];
		mid_re = 1'b0;
		mid_ra = key[hbsu_pkg::KEY_BITS-1 -: LO];
		if (accept) begin
			leaf_re = 1'b1;
			mid_re = 1'b1;
		end else if (state_q == S_DECIDE && !hit0_q && hit1_q) begin
			leaf_re = 1'b1;
			leaf_ra = {d_hi, r1_q};
		end else if (state_q == S_DECIDE && !hit0_q && hit2_q) begin
			mid_re = 1'b1;
			mid_ra = r2_q;
		end else if (state_q == S_MID) begin
			leaf_re = 1'b1;
			leaf_ra = {top_idx_q, mid_pick};
		end
	end

	always_comb begin
		leaf_we = 1'b0;
		leaf_wa = key_q[hbsu_pkg::KEY_BITS-1:LO];
		leaf_wd = leaf_new;
		mid_we = 1'b0;
		mid_wa = d_hi;
		mid_wd = mid_new;
		if (state_q == S_CLEAR) begin
			leaf_we = 1'b1;
			leaf_wa = clr_q;
			leaf_wd = '0;
			mid_we = 1'b1;
			mid_wa = clr_q[hbsu_pkg::MID_ADDR_BITS-1:0];
			mid_wd = '0;
		end else if (state_q == S_LOOK && op_q == hbsu_pkg::REQ_TOGGLE) begin
			leaf_we = 1'b1;
			mid_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (leaf_we) begin
			leaf_mem[leaf_wa] <= leaf_wd;
		end
		if (leaf_re) begin
			leaf_rd_q <= leaf_mem[leaf_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (mid_we) begin
			mid_mem[mid_wa] <= mid_wd;
		end
		if (mid_re) begin
			mid_rd_q <= mid_mem[mid_ra];
		end
	end

	assign load_out = (state_q == S_DONE) && (!res_valid_q || !res_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == '1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				if (op_q == hbsu_pkg::REQ_NEXT || op_q == hbsu_pkg::REQ_PREV) begin
					state_d = S_DECIDE;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DECIDE: begin
				if (hit0_q || (!hit1_q && !hit2_q)) begin
					state_d = S_DONE;
				end else if (hit1_q) begin
					state_d = S_LEAF;
				end else begin
					state_d = S_MID;
				end
			end
			S_MID: state_d = S_LEAF;
			S_LEAF: state_d = S_DONE;
			S_DONE: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			top_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + hbsu_pkg::leaf_addr_t'(1);
			end
			if (state_q == S_LOOK && op_q == hbsu_pkg::REQ_TOGGLE) begin
				top_q[d_hi] <= (mid_new != '0);
			end
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req_type;
			key_q <= key;
		end
		if (state_q == S_LOOK) begin
			hit0_q <= (lw != '0);
			hit1_q <= (mw != '0);
			hit2_q <= (tw != '0);
			r0_q <= hbsu_pkg::pick_index(upward, lw);
			r1_q <= hbsu_pkg::pick_index(upward, mw);
			r2_q <= hbsu_pkg::pick_index(upward, tw);
		end
		if (state_q == S_DECIDE) begin
			top_idx_q <= r2_q;
			leaf_idx_q <= {d_hi, r1_q};
			fnd_q <= hit0_q;
			pos_q <= hit0_q ? {key_q[hbsu_pkg::KEY_BITS-1:LO], r0_q} : '0;
		end
		if (state_q == S_MID) begin
			leaf_idx_q <= {top_idx_q, mid_pick};
		end
		if (state_q == S_LEAF) begin
			fnd_q <= 1'b1;
			pos_q <= {leaf_idx_q, leaf_pick};
		end
		if (load_out) begin
			res_found_q <= fnd_q;
			res_pos_q <= pos_q;
		end
	end

	assign res_valid = res_valid_q;
	assign found = res_found_q;
	assign position = res_pos_q;

	`HBSU_ASSERT_ALWAYS(a_no_result_in_clear, (state_q == S_CLEAR) |-> !res_valid_q, "result during clear")
	`HBSU_ASSERT(a_rise_from_done, $rose(res_valid_q) |-> $past(state_q == S_DONE), "result without search")
	`HBSU_ASSERT(a_next_not_below, (state_q == S_DONE && fnd_q && op_q == hbsu_pkg::REQ_NEXT) |-> (pos_q >= key_q), "next below key")
	`HBSU_ASSERT(a_prev_below, (state_q == S_DONE && fnd_q && op_q == hbsu_pkg::REQ_PREV) |-> (pos_q < key_q), "prev not below key")
	`HBSU_ASSERT(a_miss_zero, (res_valid_q && !res_found_q) |-> (res_pos_q == '0), "miss with nonzero position")

endmodule

[verif/hierarchical_bitmap_successor_unit_tb.sv]
`timescale 1ns / 1ps

module hierarchical_bitmap_successor_unit_tb;
	import hbsu_pkg::*;

	typedef struct packed {
		logic found;
		key_t position;
	} result_t;

	typedef struct packed {
		logic [1:0] op;
		key_t       k;
		logic       typed;
		logic       exp_found;
		key_t       exp_pos;
	} stim_row_t;

	localparam key_t KEY_MAX = {KEY_BITS{1'b1}};
	localparam int N_DIRECTED = 24;
	localparam int N_RANDOM_PHASE = 375;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	logic [1:0] req_type = REQ_NONE;
	key_t       key = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic       found;
	key_t       position;

	word_t   top_word;
	word_t   mid_words [MID_DEPTH];
	word_t   leaf_words [LEAF_DEPTH];
	result_t pending_results [$];
	key_t    member_log [$];
	key_t    focus_key = '0;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int error_count = 0;
	int toggle_count = 0;
	int search_count = 0;
	int hit_count = 0;

	stim_row_t directed_rows [N_DIRECTED] = '{
		'{REQ_NEXT,   key_t'(0),        1'b1, 1'b0, key_t'(0)},
		'{REQ_PREV,   KEY_MAX,          1'b1, 1'b0, key_t'(0)},
		'{REQ_NEXT,   KEY_MAX,          1'b1, 1'b0, key_t'(0)},
		'{REQ_PREV,   key_t'(0),        1'b1, 1'b0, key_t'(0)},
		'{REQ_NONE,   KEY_MAX,          1'b0, 1'b0, key_t'(0)},
		'{REQ_TOGGLE, key_t'(0),        1'b0, 1'b0, key_t'(0)},
		'{REQ_NEXT,   key_t'(0),        1'b1, 1'b1, key_t'(0)},
		'{REQ_PREV,   key_t'(0),        1'b1, 1'b0, key_t'(0)},
		'{REQ_NEXT,   key_t'(1),        1'b0, 1'b0, key_t'(0)},
		'{REQ_TOGGLE, KEY_MAX,          1'b0, 1'b0, key_t'(0)},
		'{REQ_NEXT,   key_t'(1),        1'b0, 1'b0, key_t'(0)},
		'{REQ_NEXT,   KEY_MAX,          1'b1, 1'b1, KEY_MAX},
		'{REQ_PREV,   KEY_MAX,          1'b1, 1'b1, key_t'(0)},
		'{REQ_TOGGLE, key_t'('h10fc7),  1'b0, 1'b0, key_t'(0)},
		'{REQ_PREV,   key_t'('h10fc8),  1'b0, 1'b0, key_t'(0)},
		'{REQ_NEXT,   key_t'('h00040),  1'b0, 1'b0, key_t'(0)},
		'{REQ_PREV,   key_t'('h20000),  1'b0, 1'b0, key_t'(0)},
		'{REQ_TOGGLE, key_t'('h10fc7),  1'b0, 1'b0, key_t'(0)},
		'{REQ_NEXT,   key_t'(1),        1'b0, 1'b0, key_t'(0)},
		'{REQ_TOGGLE, key_t'(0),        1'b0, 1'b0, key_t'(0)},
		'{REQ_PREV,   KEY_MAX,          1'b0, 1'b0, key_t'(0)},
		'{REQ_NONE,   key_t'('h15555),  1'b0, 1'b0, key_t'(0)},
		'{REQ_TOGGLE, KEY_MAX,          1'b0, 1'b0, key_t'(0)},
		'{REQ_NEXT,   key_t'('h2aaaa),  1'b1, 1'b0, key_t'(0)}
	};

	hierarchical_bitmap_successor_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type (req_type),
		.key      (key),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.found    (found),
		.position (position)
	);

	always #5 clk = ~clk;

	function automatic int first_at(input word_t w, input int from);
		for (int i = from; i < WORD_BITS; i++) begin
			if (w[i]) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic int last_below(input word_t w, input int below);
		for (int i = below - 1; i >= 0; i--) begin
			if (w[i]) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic void flip_key(input key_t k);
		int l;
		int m;
		l = int'(k) >> WORD_LOG;
		m = l >> WORD_LOG;
		leaf_words[l][int'(k) % WORD_BITS] ^= 1'b1;
		mid_words[m][l % WORD_BITS] = (leaf_words[l] != '0);
		top_word[m] = (mid_words[m] != '0);
	endfunction

	function automatic result_t find_member(input key_t k, input logic upward);
		int r;
		int w;
		int l;
		l = int'(k) >> WORD_LOG;
		r = upward ? first_at(leaf_words[l], int'(k) % WORD_BITS)
			: last_below(leaf_words[l], int'(k) % WORD_BITS);
		if (r >= 0) begin
			return '{1'b1, key_t'(l * WORD_BITS + r)};
		end
		w = l >> WORD_LOG;
		r = upward ? first_at(mid_words[w], l % WORD_BITS + 1)
			: last_below(mid_words[w], l % WORD_BITS);
		if (r < 0) begin
			r = upward ? first_at(top_word, w + 1) : last_below(top_word, w);
			if (r < 0) begin
				return '{1'b0, key_t'(0)};
			end
			w = r;
			r = upward ? first_at(mid_words[w], 0) : last_below(mid_words[w], WORD_BITS);
		end
		l = w * WORD_BITS + r;
		r = upward ? first_at(leaf_words[l], 0) : last_below(leaf_words[l], WORD_BITS);
		return '{1'b1, key_t'(l * WORD_BITS + r)};
	endfunction

	function automatic void predict(input logic [1:0] op, input key_t k, input logic typed,
			input result_t typed_res);
		case (op)
			REQ_TOGGLE: begin
				flip_key(k);
				toggle_count++;
				member_log.push_back(k);
				if (member_log.size() > 512) begin
					void'(member_log.pop_front());
				end
			end
			REQ_NEXT, REQ_PREV: begin
				search_count++;
				pending_results.push_back(typed ? typed_res : find_member(k, op == REQ_NEXT));
			end
			default: begin
			end
		endcase
	endfunction

	function automatic key_t pick_key();
		key_t k;
		case ($urandom_range(5))
			0: k = key_t'($urandom);
			1: k = focus_key + key_t'($urandom_range(255));
			2: begin
				if (member_log.size() != 0) begin
					k = member_log[$urandom_range(member_log.size() - 1)]
						+ key_t'($urandom_range(6)) - key_t'(3);
				end else begin
					k = key_t'($urandom);
				end
			end
			3: begin
				k = key_t'($urandom);
				if ($urandom_range(1)) begin
					k[WORD_LOG-1:0] = {WORD_LOG{k[0]}};
				end else begin
					k[2*WORD_LOG-1:0] = {2*WORD_LOG{k[0]}};
				end
			end
			default: k = focus_key + key_t'($urandom_range(8191));
		endcase
		return k;
	endfunction

	task automatic send_req(input logic [1:0] op, input key_t k);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= op;
		key <= k;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_results.size() != 0);
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (found === 1'b1) begin
				hit_count++;
			end
			if (pending_results.size() == 0) begin
				$error("unexpected transaction: found %0d position %0d", found, position);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, found);
					error_count++;
				end
				if (position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, position);
					error_count++;
				end
			end
		end
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		logic [1:0] op;
		key_t k;
		int sel;
		top_word = '0;
		foreach (mid_words[i]) mid_words[i] = '0;
		foreach (leaf_words[i]) leaf_words[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			send_req(directed_rows[i].op, directed_rows[i].k);
			predict(directed_rows[i].op, directed_rows[i].k, directed_rows[i].typed,
				'{directed_rows[i].exp_found, directed_rows[i].exp_pos});
		end
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 52; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 52; end
				default: begin send_idle_pct = 18; stall_pct = 18; end
			endcase
			for (int n = 0; n < N_RANDOM_PHASE; n++) begin
				if ($urandom_range(49) == 0) begin
					focus_key = key_t'($urandom);
				end
				sel = $urandom_range(99);
				if (sel < 35) begin
					op = REQ_TOGGLE;
				end else if (sel < 65) begin
					op = REQ_NEXT;
				end else if (sel < 96) begin
					op = REQ_PREV;
				end else begin
					op = REQ_NONE;
				end
				if (op == REQ_TOGGLE && member_log.size() != 0 && $urandom_range(3) == 0) begin
					k = member_log[$urandom_range(member_log.size() - 1)];
				end else begin
					k = pick_key();
				end
				send_req(op, k);
				predict(op, k, 1'b0, '{1'b0, key_t'(0)});
			end
			// hold the request side until every result is back
			drain();
		end

		repeat (20) @(posedge clk);
		$display("covered %0d toggles and %0d searches (%0d found) under four idle/stall mixes",
			toggle_count, search_count, hit_count);
		if (error_count == 0) begin
			$display("hierarchical_bitmap_successor_unit_tb OK");
		end else begin
			$display("hierarchical_bitmap_successor_unit_tb NOT OK");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("hierarchical_bitmap_successor_unit_tb NOT OK");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/hbsu_pkg.sv
hw/rtl/hierarchical_bitmap_successor_unit.sv
verif/hierarchical_bitmap_successor_unit_tb.sv
